>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RWCH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rwch assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RWCH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rwch assertion failed");

`endif

>>> sv/rwch_pkg.sv
// ----------------------------------------------------------------------------
// rwch_pkg
// Shared widths, constants and request structs of the ray/wall hit core.
// ----------------------------------------------------------------------------
package rwch_pkg;

  localparam int MAX_SEGMENTS_DEF = 1024;
  localparam int BOUND_MARGIN_DEF = 64;
  localparam int MAX_DISTANCE_DEF = 1024;

  localparam int CRDW  = 18;  // endpoint coordinate, wide enough for grown bounds
  localparam int SEGW  = 19;  // endpoint difference
  localparam int RW    = 23;  // endpoint minus origin, Q.4
  localparam int DETW  = 36;
  localparam int TNW   = 43;
  localparam int UNW   = 40;
  localparam int LSQW  = 38;  // squared segment length
  localparam int DENW  = 35;  // |det|
  localparam int NUMW  = 61;  // divider numerator
  localparam int SQW   = 54;  // square root radicand
  localparam int ROOTW = 27;
  localparam int UQW   = 17;
  localparam int OFFW  = 25;
  localparam int DISTW = 18;
  localparam int LINEW = 10;

  localparam int DET_MIN    = 2;
  localparam int NEAR_SHIFT = 11;
  localparam int TQ_SHIFT   = 18;
  localparam int UQ_SHIFT   = 12;
  localparam int SQ_SHIFT   = 16;
  localparam int DIST_MAX   = 262143;
  localparam int OFFS_MAX   = 33554431;
  localparam int NUM_EDGES  = 4;

  // configuration register indexes
  localparam logic [2:0] REG_SEG_COUNT = 3'd0;
  localparam logic [2:0] REG_MIN_X     = 3'd1;
  localparam logic [2:0] REG_MAX_X     = 3'd2;
  localparam logic [2:0] REG_MIN_Y     = 3'd3;
  localparam logic [2:0] REG_MAX_Y     = 3'd4;

  // bound edges in test order
  localparam logic [1:0] EDGE_LEFT   = 2'd0;
  localparam logic [1:0] EDGE_RIGHT  = 2'd1;
  localparam logic [1:0] EDGE_BOTTOM = 2'd2;
  localparam logic [1:0] EDGE_TOP    = 2'd3;

  typedef struct packed {
    logic            start;
    logic [NUMW-1:0] num;
    logic [DENW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           start;
    logic [SQW-1:0] rad;
  } sqrt_req_t;

endpackage

>>> sv/rwch_div.sv
// ----------------------------------------------------------------------------
// rwch_div
// Restoring divider, one quotient bit per cycle; quotient must fit QW bits.
// ----------------------------------------------------------------------------
module rwch_div import rwch_pkg::*; #(
  parameter int QW = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  div_req_t      req_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  localparam int CW = $clog2(QW + 1);

  logic [DENW-1:0] rem_q, rem_d, den_q, den_d;
  logic [QW-1:0]   low_q, low_d, quot_q, quot_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            run_q, run_d, done_q, done_d;
  logic [DENW:0]   trial;
  logic            ge;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q, low_q[QW-1]};
    ge     = trial >= {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = DENW'(req_i.num >> QW);
      low_d  = req_i.num[QW-1:0];
      den_d  = req_i.den;
      quot_d = '0;
      cnt_d  = CW'(QW);
      run_d  = 1'b1;
    end else if (run_q) begin
      rem_d  = ge ? DENW'(trial - {1'b0, den_q}) : DENW'(trial);
      low_d  = {low_q[QW-2:0], 1'b0};
      quot_d = {quot_q[QW-2:0], ge};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> sv/rwch_sqrt.sv
// ----------------------------------------------------------------------------
// rwch_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rwch_sqrt import rwch_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sqrt_req_t        req_i,
  output logic             done_o,
  output logic [ROOTW-1:0] root_o
);

  localparam int ITER = SQW / 2;
  localparam int CW   = $clog2(ITER + 1);

  logic [SQW-1:0] v_q, v_d, r_q, r_d, bit_q, bit_d, sum;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           run_q, run_d, done_q, done_d;

  always_comb begin
    v_d    = v_q;
    r_d    = r_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    sum    = r_q + bit_q;
    if (req_i.start) begin
      v_d   = req_i.rad;
      r_d   = '0;
      bit_d = SQW'(1) << (SQW - 2);
      cnt_d = CW'(ITER);
      run_d = 1'b1;
    end else if (run_q) begin
      if (v_q >= sum) begin
        v_d = v_q - sum;
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOTW-1:0];

endmodule

>>> sv/ray_wall_closest_hit_core.sv
// ----------------------------------------------------------------------------
// ray_wall_closest_hit_core
// Nearest hit of a ray against a table of wall segments and the grown bounds.
// ----------------------------------------------------------------------------
// channel   | handshake                | payload
// request   | start_i / busy_o         | req_type_i, seg_index_i, end_*_i, origin_*_i, dir_*_i
// result    | hit_valid_o (strobe)     | hit_*_o
// config    | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A load is accepted in idle; its result strobes in the next cycle.
// A cast walks the table one entry at a time through the single memory port:
// FETCH and WAIT read an entry; a non-blocking one goes to NEXT, a blocking one
// runs MUL, SUB, CHECK and, if it passes, the distance division (DIVT), then, if
// nearer, a second division, the root and the offset (DIVU, SQRT, OFF). Bound edges
// skip the memory read. DONE ends the cast, the result strobing as busy_o falls.
// Reset starts a pass zeroing the table, busy_o high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module ray_wall_closest_hit_core import rwch_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int BOUND_MARGIN = BOUND_MARGIN_DEF,
  parameter int MAX_DISTANCE = MAX_DISTANCE_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    req_type_i,
  input  logic [9:0]              seg_index_i,
  input  logic signed [15:0]      end_a_x_i,
  input  logic signed [15:0]      end_a_y_i,
  input  logic signed [15:0]      end_b_x_i,
  input  logic signed [15:0]      end_b_y_i,
  input  logic                    seg_blocks_i,
  input  logic signed [19:0]      origin_x_i,
  input  logic signed [19:0]      origin_y_i,
  input  logic signed [15:0]      dir_x_i,
  input  logic signed [15:0]      dir_y_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  output logic                    hit_valid_o,
  output logic                    hit_found_o,
  output logic                    hit_is_boundary_o,
  output logic [LINEW-1:0]        hit_line_o,
  output logic [DISTW-1:0]        hit_distance_o,
  output logic [OFFW-1:0]         hit_offset_o,
  output logic [UQW-1:0]          hit_u_o
);

  localparam int AW        = $clog2(MAX_SEGMENTS);
  localparam int CNTW      = AW + 1;
  localparam int LW        = (AW > LINEW) ? AW : LINEW;
  localparam int BEST_INIT = MAX_DISTANCE * 256;
  localparam int TQW       = $clog2(BEST_INIT + 1);
  localparam int QW        = (TQW > UQW) ? TQW : UQW;
  localparam int CMPW      = (NUMW > DENW + QW) ? NUMW : DENW + QW;
  localparam int MEMW      = 65;

  typedef enum logic [12:0] {
    ST_CLEAR = 13'b0000000000001,
    ST_IDLE  = 13'b0000000000010,
    ST_FETCH = 13'b0000000000100,
    ST_WAIT  = 13'b0000000001000,
    ST_MUL   = 13'b0000000010000,
    ST_SUB   = 13'b0000000100000,
    ST_CHECK = 13'b0000001000000,
    ST_DIVT  = 13'b0000010000000,
    ST_DIVU  = 13'b0000100000000,
    ST_SQRT  = 13'b0001000000000,
    ST_OFF   = 13'b0010000000000,
    ST_NEXT  = 13'b0100000000000,
    ST_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [10:0]        segcnt_q, segcnt_d;
  logic signed [15:0] bmin_x_q, bmin_x_d, bmax_x_q, bmax_x_d;
  logic signed [15:0] bmin_y_q, bmin_y_d, bmax_y_q, bmax_y_d;

  // walk control
  logic [AW-1:0]   clr_q, clr_d;
  logic [CNTW-1:0] i_q, i_d, limit_q, limit_d;
  logic [2:0]      e_q, e_d;
  logic            edge_q, edge_d, seg_hit_q, seg_hit_d, edge_hit_q, edge_hit_d;
  logic            hit_valid_q, hit_valid_d;

  // table memory: {flag, b_y, b_x, a_y, a_x}
  logic [MEMW-1:0] seg_mem [MAX_SEGMENTS];
  logic [MEMW-1:0] mem_rdata_q, mem_wdata;
  logic [AW-1:0]   mem_waddr;
  logic            mem_we, mem_re;

  // datapath
  logic signed [19:0]      ox_q, ox_d, oy_q, oy_d;
  logic signed [15:0]      dx_q, dx_d, dy_q, dy_d;
  logic signed [CRDW-1:0]  ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic signed [SEGW-1:0]  sx_c, sy_c;
  logic signed [RW-1:0]    rx_c, ry_c;
  logic signed [34:0]      p_dxsy_q, p_dysx_q;
  logic signed [41:0]      p_rxsy_q, p_rysx_q;
  logic signed [38:0]      p_rxdy_q, p_rydx_q;
  logic signed [37:0]      p_sxsx_q, p_sysy_q;
  logic signed [DETW-1:0]  det_q, adet_c;
  logic signed [TNW-1:0]   tn_q, ntn_c;
  logic signed [UNW-1:0]   un_q, nun_c, adet16_c;
  logic [LSQW-1:0]         lsq_q;
  logic [DENW-1:0]         adet_q, adet_d;
  logic [UNW-1:0]          nun_q, nun_d;
  logic [NUMW-1:0]         n_t_c;
  logic [DENW-1:0]         d_c;
  logic                    rej_par, rej_near, rej_u, rej_ovf, pass_c;
  logic [TQW-1:0]          best_t_q, best_t_d, tq_q, tq_d;
  logic [OFFW-1:0]         best_off_q, best_off_d;
  logic [UQW-1:0]          best_u_q, best_u_d, uq_q, uq_d;
  logic [ROOTW-1:0]        len_q, len_d;
  logic [AW-1:0]           line_q, line_d;
  logic [UQW+ROOTW-1:0]    offp_c;
  logic [UQW+ROOTW-1:0]    offs_c;
  logic signed [CRDW-1:0]  mnx_c, mxx_c, mny_c, mxy_c;
  logic [LW-1:0]           line_ext_c;

  // result registers
  logic             found_q, found_d, bnd_q, bnd_d;
  logic [LINEW-1:0] rline_q, rline_d;
  logic [DISTW-1:0] rdist_q, rdist_d;
  logic [OFFW-1:0]  roff_q, roff_d;
  logic [UQW-1:0]   ru_q, ru_d;

  // arithmetic units (the divider serves both divisions)
  div_req_t        div_req;
  sqrt_req_t       sqrt_req;
  logic            div_done, sqrt_done;
  logic [QW-1:0]   div_quot;
  logic [ROOTW-1:0] sqrt_root;

  rwch_div #(.QW(QW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  rwch_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  // segment geometry
  assign sx_c = SEGW'(bx_q) - SEGW'(ax_q);
  assign sy_c = SEGW'(by_q) - SEGW'(ay_q);
  assign rx_c = (RW'(ax_q) <<< 4) - RW'(ox_q);
  assign ry_c = (RW'(ay_q) <<< 4) - RW'(oy_q);

  // orientation fix and rejection tests
  always_comb begin
    adet_c   = det_q[DETW-1] ? -det_q : det_q;
    ntn_c    = det_q[DETW-1] ? -tn_q  : tn_q;
    nun_c    = det_q[DETW-1] ? -un_q  : un_q;
    adet16_c = UNW'(adet_c) <<< 4;
    n_t_c    = NUMW'(ntn_c) << TQ_SHIFT;
    d_c      = DENW'(adet_c);
    rej_par  = adet_c < DETW'(DET_MIN);
    rej_near = (($signed((TNW + NEAR_SHIFT)'(ntn_c))) <<< NEAR_SHIFT)
               <= $signed((TNW + NEAR_SHIFT)'(adet_c));
    rej_u    = nun_c[UNW-1] || (nun_c > adet16_c);
    rej_ovf  = CMPW'(n_t_c) >= (CMPW'(d_c) << QW);
    pass_c   = !(rej_par || rej_near || rej_u || rej_ovf);
  end

  assign mnx_c = CRDW'(bmin_x_q) - CRDW'(BOUND_MARGIN);
  assign mxx_c = CRDW'(bmax_x_q) + CRDW'(BOUND_MARGIN);
  assign mny_c = CRDW'(bmin_y_q) - CRDW'(BOUND_MARGIN);
  assign mxy_c = CRDW'(bmax_y_q) + CRDW'(BOUND_MARGIN);

  assign offp_c = UQW'(uq_q) * (UQW + ROOTW)'(len_q);
  assign offs_c = offp_c >> 16;
  assign line_ext_c = LW'(line_q);

  always_comb begin
    state_d     = state_q;
    segcnt_d    = segcnt_q;
    bmin_x_d    = bmin_x_q;
    bmax_x_d    = bmax_x_q;
    bmin_y_d    = bmin_y_q;
    bmax_y_d    = bmax_y_q;
    clr_d       = clr_q;
    i_d         = i_q;
    limit_d     = limit_q;
    e_d         = e_q;
    edge_d      = edge_q;
    seg_hit_d   = seg_hit_q;
    edge_hit_d  = edge_hit_q;
    hit_valid_d = 1'b0;
    ox_d = ox_q; oy_d = oy_q; dx_d = dx_q; dy_d = dy_q;
    ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q;
    adet_d      = adet_q;
    nun_d       = nun_q;
    best_t_d    = best_t_q;
    best_off_d  = best_off_q;
    best_u_d    = best_u_q;
    tq_d        = tq_q;
    uq_d        = uq_q;
    len_d       = len_q;
    line_d      = line_q;
    found_d = found_q; bnd_d = bnd_q; rline_d = rline_q;
    rdist_d = rdist_q; roff_d = roff_q; ru_d = ru_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = '0;
    div_req     = '0;
    sqrt_req    = '0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SEG_COUNT: segcnt_d = cfg_data_i[10:0];
        REG_MIN_X:     bmin_x_d = cfg_data_i;
        REG_MAX_X:     bmax_x_d = cfg_data_i;
        REG_MIN_Y:     bmin_y_d = cfg_data_i;
        REG_MAX_Y:     bmax_y_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(MAX_SEGMENTS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          if (!req_type_i) begin
            if (32'(seg_index_i) < MAX_SEGMENTS) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(seg_index_i);
              mem_wdata = {seg_blocks_i, end_b_y_i, end_b_x_i, end_a_y_i, end_a_x_i};
            end
            hit_valid_d = 1'b1;
            found_d = 1'b0; bnd_d = 1'b0; rline_d = '0;
            rdist_d = '0;   roff_d = '0;  ru_d = '0;
          end else begin
            ox_d = origin_x_i; oy_d = origin_y_i; dx_d = dir_x_i; dy_d = dir_y_i;
            limit_d    = (32'(segcnt_q) > MAX_SEGMENTS) ? CNTW'(MAX_SEGMENTS)
                                                       : CNTW'(segcnt_q);
            i_d        = '0;
            e_d        = '0;
            edge_d     = 1'b0;
            seg_hit_d  = 1'b0;
            edge_hit_d = 1'b0;
            best_t_d   = TQW'(BEST_INIT);
            best_off_d = '0;
            best_u_d   = '0;
            line_d     = '0;
            state_d    = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        if (!edge_q && (i_q < limit_q)) begin
          mem_re  = 1'b1;
          state_d = ST_WAIT;
        end else if (32'(e_q) < NUM_EDGES) begin
          edge_d = 1'b1;
          unique case (e_q[1:0])
            EDGE_LEFT:   begin ax_d = mnx_c; ay_d = mny_c; bx_d = mnx_c; by_d = mxy_c; end
            EDGE_RIGHT:  begin ax_d = mxx_c; ay_d = mny_c; bx_d = mxx_c; by_d = mxy_c; end
            EDGE_BOTTOM: begin ax_d = mnx_c; ay_d = mny_c; bx_d = mxx_c; by_d = mny_c; end
            EDGE_TOP:    begin ax_d = mnx_c; ay_d = mxy_c; bx_d = mxx_c; by_d = mxy_c; end
          endcase
          state_d = ST_MUL;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WAIT: begin
        ax_d = CRDW'($signed(mem_rdata_q[15:0]));
        ay_d = CRDW'($signed(mem_rdata_q[31:16]));
        bx_d = CRDW'($signed(mem_rdata_q[47:32]));
        by_d = CRDW'($signed(mem_rdata_q[63:48]));
        state_d = mem_rdata_q[64] ? ST_MUL : ST_NEXT;
      end
      ST_MUL: state_d = ST_SUB;
      ST_SUB: state_d = ST_CHECK;
      ST_CHECK: begin
        adet_d = d_c;
        nun_d  = nun_c;
        if (pass_c) begin
          div_req.start = 1'b1;
          div_req.num   = n_t_c;
          div_req.den   = d_c;
          state_d       = ST_DIVT;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_DIVT: begin
        if (div_done) begin
          // ties keep the earlier candidate
          if (div_quot >= QW'(best_t_q)) begin
            state_d = ST_NEXT;
          end else begin
            tq_d          = TQW'(div_quot);
            div_req.start = 1'b1;
            div_req.num   = NUMW'(nun_q) << UQ_SHIFT;
            div_req.den   = adet_q;
            state_d       = ST_DIVU;
          end
        end
      end
      ST_DIVU: begin
        if (div_done) begin
          uq_d           = UQW'(div_quot);
          sqrt_req.start = 1'b1;
          sqrt_req.rad   = SQW'(lsq_q) << SQ_SHIFT;
          state_d        = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          len_d   = sqrt_root;
          state_d = ST_OFF;
        end
      end
      ST_OFF: begin
        best_t_d   = tq_q;
        best_u_d   = uq_q;
        best_off_d = (offs_c > (UQW + ROOTW)'(OFFS_MAX)) ? OFFW'(OFFS_MAX) : OFFW'(offs_c);
        if (edge_q) begin
          edge_hit_d = 1'b1;
        end else begin
          seg_hit_d = 1'b1;
          line_d    = i_q[AW-1:0];
        end
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (edge_q) e_d = e_q + 3'd1;
        else        i_d = i_q + CNTW'(1);
        state_d = ST_FETCH;
      end
      ST_DONE: begin
        hit_valid_d = 1'b1;
        found_d     = seg_hit_q || edge_hit_q;
        bnd_d       = edge_hit_q;
        if (seg_hit_q || edge_hit_q) begin
          rline_d = edge_hit_q ? '0 : line_ext_c[LINEW-1:0];
          rdist_d = (32'(best_t_q) > DIST_MAX) ? DISTW'(DIST_MAX) : DISTW'(best_t_q);
          roff_d  = best_off_q;
          ru_d    = best_u_q;
        end else begin
          rline_d = '0; rdist_d = '0; roff_d = '0; ru_d = '0;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      segcnt_q    <= '0;
      bmin_x_q    <= '0;
      bmax_x_q    <= '0;
      bmin_y_q    <= '0;
      bmax_y_q    <= '0;
      clr_q       <= '0;
      i_q         <= '0;
      limit_q     <= '0;
      e_q         <= '0;
      edge_q      <= 1'b0;
      seg_hit_q   <= 1'b0;
      edge_hit_q  <= 1'b0;
      hit_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      segcnt_q    <= segcnt_d;
      bmin_x_q    <= bmin_x_d;
      bmax_x_q    <= bmax_x_d;
      bmin_y_q    <= bmin_y_d;
      bmax_y_q    <= bmax_y_d;
      clr_q       <= clr_d;
      i_q         <= i_d;
      limit_q     <= limit_d;
      e_q         <= e_d;
      edge_q      <= edge_d;
      seg_hit_q   <= seg_hit_d;
      edge_hit_q  <= edge_hit_d;
      hit_valid_q <= hit_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q <= ox_d; oy_q <= oy_d; dx_q <= dx_d; dy_q <= dy_d;
    ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d;
    p_dxsy_q <= dx_q * sy_c;
    p_dysx_q <= dy_q * sx_c;
    p_rxsy_q <= rx_c * sy_c;
    p_rysx_q <= ry_c * sx_c;
    p_rxdy_q <= rx_c * dy_q;
    p_rydx_q <= ry_c * dx_q;
    p_sxsx_q <= sx_c * sx_c;
    p_sysy_q <= sy_c * sy_c;
    det_q    <= DETW'(p_dxsy_q) - DETW'(p_dysx_q);
    tn_q     <= TNW'(p_rxsy_q) - TNW'(p_rysx_q);
    un_q     <= UNW'(p_rxdy_q) - UNW'(p_rydx_q);
    lsq_q    <= LSQW'(p_sxsx_q[36:0]) + LSQW'(p_sysy_q[36:0]);
    adet_q     <= adet_d;
    nun_q      <= nun_d;
    best_t_q   <= best_t_d;
    best_off_q <= best_off_d;
    best_u_q   <= best_u_d;
    tq_q       <= tq_d;
    uq_q       <= uq_d;
    len_q      <= len_d;
    line_q     <= line_d;
    found_q <= found_d; bnd_q <= bnd_d; rline_q <= rline_d;
    rdist_q <= rdist_d; roff_q <= roff_d; ru_q <= ru_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) seg_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= seg_mem[i_q[AW-1:0]];
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign hit_valid_o       = hit_valid_q;
  assign hit_found_o       = found_q;
  assign hit_is_boundary_o = bnd_q;
  assign hit_line_o        = rline_q;
  assign hit_distance_o    = rdist_q;
  assign hit_offset_o      = roff_q;
  assign hit_u_o           = ru_q;

endmodule

>>> sv/rwch_checker.sv
// ----------------------------------------------------------------------------
// rwch_checker
// Port-level checks of the ray/wall hit core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rwch_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        req_type_i,
  input logic        hit_valid_o,
  input logic        hit_found_o,
  input logic        hit_is_boundary_o,
  input logic [9:0]  hit_line_o,
  input logic [17:0] hit_distance_o,
  input logic [24:0] hit_offset_o,
  input logic [16:0] hit_u_o
);

  // a load request answers in the next cycle with a miss
  `RWCH_ASSERT_NXT(a_load_result, clk_i, rst_ni, start_i && !busy_o && !req_type_i, hit_valid_o && !hit_found_o)
  `RWCH_ASSERT_NXT(a_cast_busy, clk_i, rst_ni, start_i && !busy_o && req_type_i, busy_o && !hit_valid_o)
  `RWCH_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, hit_valid_o && !hit_found_o, !hit_is_boundary_o && hit_line_o == 10'd0 && hit_distance_o == 18'd0 && hit_offset_o == 25'd0 && hit_u_o == 17'd0)
  `RWCH_ASSERT_IMP(a_bound_line, clk_i, rst_ni, hit_valid_o && hit_is_boundary_o, hit_found_o && hit_line_o == 10'd0)
  `RWCH_ASSERT_IMP(a_u_range, clk_i, rst_ni, hit_valid_o, hit_u_o <= 17'd65536)

endmodule

bind ray_wall_closest_hit_core rwch_checker u_rwch_checker (.*);

>>> sim/tb_ray_wall_closest_hit_core.sv
// ----------------------------------------------------------------------------
// tb_ray_wall_closest_hit_core
// Self-checking bench for the ray/wall closest hit core: drives load and cast
// requests, predicts each hit in exact integer arithmetic and checks every
// result strobe in order against the predicted hit.
// ----------------------------------------------------------------------------
module tb_ray_wall_closest_hit_core;
  import rwch_pkg::*;

  localparam bit REQ_LOAD = 1'b0;
  localparam bit REQ_CAST = 1'b1;
  localparam int TABLE_DEPTH = 1024;

  typedef struct {
    bit          kind;
    bit [9:0]    idx;
    shortint     ax, ay, bx, by;
    bit          blk;
    int          ox, oy;
    shortint     dx, dy;
  } ray_req_t;

  typedef struct packed {
    logic             found;
    logic             boundary;
    logic [LINEW-1:0] line;
    logic [DISTW-1:0] distance;
    logic [OFFW-1:0]  offs;
    logic [UQW-1:0]   u;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic req_type_i = 1'b0;
  logic [9:0] seg_index_i = '0;
  logic signed [15:0] end_a_x_i = '0, end_a_y_i = '0, end_b_x_i = '0, end_b_y_i = '0;
  logic seg_blocks_i = 1'b0;
  logic signed [19:0] origin_x_i = '0, origin_y_i = '0;
  logic signed [15:0] dir_x_i = '0, dir_y_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic busy_o, cfg_ready_o, hit_valid_o, hit_found_o, hit_is_boundary_o;
  logic [LINEW-1:0] hit_line_o;
  logic [DISTW-1:0] hit_distance_o;
  logic [OFFW-1:0] hit_offset_o;
  logic [UQW-1:0] hit_u_o;

  // predictor state
  shortint  wall_ax [TABLE_DEPTH];
  shortint  wall_ay [TABLE_DEPTH];
  shortint  wall_bx [TABLE_DEPTH];
  shortint  wall_by [TABLE_DEPTH];
  bit       wall_blocks [TABLE_DEPTH];
  bit [10:0] walk_count = '0;
  shortint  map_min_x = 0, map_max_x = 0, map_min_y = 0, map_max_y = 0;

  hit_t pending_hits[$];
  int   mismatches = 0;
  bit   stray_result = 1'b0;
  int   idle_pct = 0;

  ray_wall_closest_hit_core dut (.*);

  always #5 clk_i = ~clk_i;

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // one wall against the ray; true when it becomes the nearest hit
  function automatic bit probe_wall(longint ox, longint oy, longint dx, longint dy,
                                    longint x1, longint y1, longint x2, longint y2,
                                    inout longint unsigned bt, inout longint unsigned bo,
                                    inout longint unsigned bu);
    longint sx, sy, det, rx, ry, tn, un;
    longint unsigned tq, uq, len, off;
    sx = x2 - x1;
    sy = y2 - y1;
    det = dx * sy - dy * sx;
    rx = x1 * 16 - ox;
    ry = y1 * 16 - oy;
    tn = rx * sy - ry * sx;
    un = rx * dy - ry * dx;
    if (det < 0) begin
      det = -det;
      tn = -tn;
      un = -un;
    end
    if (det < DET_MIN) return 1'b0;
    if (tn * 2048 <= det) return 1'b0;
    if (un < 0 || un > 16 * det) return 1'b0;
    tq = longint'((tn * 262144) / det);
    if (tq >= bt) return 1'b0;
    uq = longint'((un * 4096) / det);
    len = int_sqrt(longint'(sx * sx + sy * sy) << 16);
    off = (uq * len) >> 16;
    if (off > OFFS_MAX) off = OFFS_MAX;
    bt = tq;
    bo = off;
    bu = uq;
    return 1'b1;
  endfunction

  function automatic hit_t predict_hit(ray_req_t r);
    hit_t h = '0;
    longint unsigned bt = 64'd262144, bo = 0, bu = 0, best_before;
    longint mnx, mxx, mny, mxy;
    bit seg_hit = 0, edge_hit;
    int n, line = 0;
    if (r.kind == REQ_LOAD) begin
      wall_ax[r.idx] = r.ax;
      wall_ay[r.idx] = r.ay;
      wall_bx[r.idx] = r.bx;
      wall_by[r.idx] = r.by;
      wall_blocks[r.idx] = r.blk;
      return h;
    end
    n = (walk_count > TABLE_DEPTH) ? TABLE_DEPTH : walk_count;
    for (int i = 0; i < n; i++) begin
      if (wall_blocks[i] &&
          probe_wall(r.ox, r.oy, r.dx, r.dy, wall_ax[i], wall_ay[i], wall_bx[i],
                     wall_by[i], bt, bo, bu)) begin
        seg_hit = 1;
        line = i;
      end
    end
    mnx = map_min_x - 64;
    mxx = map_max_x + 64;
    mny = map_min_y - 64;
    mxy = map_max_y + 64;
    best_before = bt;
    void'(probe_wall(r.ox, r.oy, r.dx, r.dy, mnx, mny, mnx, mxy, bt, bo, bu));
    void'(probe_wall(r.ox, r.oy, r.dx, r.dy, mxx, mny, mxx, mxy, bt, bo, bu));
    void'(probe_wall(r.ox, r.oy, r.dx, r.dy, mnx, mny, mxx, mny, bt, bo, bu));
    void'(probe_wall(r.ox, r.oy, r.dx, r.dy, mnx, mxy, mxx, mxy, bt, bo, bu));
    edge_hit = bt < best_before;
    if (!seg_hit && !edge_hit) return h;
    h.found = 1'b1;
    h.boundary = edge_hit;
    h.line = edge_hit ? '0 : LINEW'(line);
    h.distance = (bt > DIST_MAX) ? DISTW'(DIST_MAX) : DISTW'(bt);
    h.offs = OFFW'(bo);
    h.u = UQW'(bu);
    return h;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    hit_t got, want;
    if (hit_valid_o) begin
      got = {hit_found_o, hit_is_boundary_o, hit_line_o, hit_distance_o, hit_offset_o,
             hit_u_o};
      if (pending_hits.size() == 0) begin
        stray_result = 1'b1;
        $display("unexpected result strobe");
      end else begin
        want = pending_hits.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("hit mismatch: exp f%0d b%0d l%0d d%0d o%0d u%0d, got f%0d b%0d l%0d d%0d o%0d u%0d",
                     want.found, want.boundary, want.line, want.distance, want.offs, want.u,
                     got.found, got.boundary, got.line, got.distance, got.offs, got.u);
        end
      end
    end
  end

  task automatic send_request(ray_req_t r);
    @(negedge clk_i);
    start_i = 1'b1;
    req_type_i = r.kind;
    seg_index_i = r.idx;
    end_a_x_i = r.ax;
    end_a_y_i = r.ay;
    end_b_x_i = r.bx;
    end_b_y_i = r.by;
    seg_blocks_i = r.blk;
    origin_x_i = 20'(r.ox);
    origin_y_i = 20'(r.oy);
    dir_x_i = r.dx;
    dir_y_i = r.dy;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    pending_hits.insert(pending_hits.size(), predict_hit(r));
    // each idle cycle taken with the given chance
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_hits.size() != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = 16'(value);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    case (idx)
      REG_SEG_COUNT: walk_count = 11'(value);
      REG_MIN_X:     map_min_x = shortint'(value);
      REG_MAX_X:     map_max_x = shortint'(value);
      REG_MIN_Y:     map_min_y = shortint'(value);
      default:       map_max_y = shortint'(value);
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_bounds(int mnx, int mxx, int mny, int mxy);
    write_reg(REG_MIN_X, mnx);
    write_reg(REG_MAX_X, mxx);
    write_reg(REG_MIN_Y, mny);
    write_reg(REG_MAX_Y, mxy);
  endtask

  function automatic int srand(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic ray_req_t load_req(int idx, int ax, int ay, int bx, int by, bit blk);
    ray_req_t r;
    r.kind = REQ_LOAD;
    r.idx = 10'(idx);
    r.ax = shortint'(ax);
    r.ay = shortint'(ay);
    r.bx = shortint'(bx);
    r.by = shortint'(by);
    r.blk = blk;
    r.ox = srand(-524288, 524287);
    r.oy = srand(-524288, 524287);
    r.dx = shortint'(srand(-16384, 16384));
    r.dy = shortint'(srand(-16384, 16384));
    return r;
  endfunction

  function automatic ray_req_t cast_req(int ox, int oy, int dx, int dy);
    ray_req_t r;
    r = load_req(srand(0, 1023), srand(-32768, 32767), srand(-32768, 32767),
                 srand(-32768, 32767), srand(-32768, 32767), $urandom_range(0, 1));
    r.kind = REQ_CAST;
    r.ox = ox;
    r.oy = oy;
    r.dx = shortint'(dx);
    r.dy = shortint'(dy);
    return r;
  endfunction

  // unit direction from a random angle
  function automatic ray_req_t local_cast();
    real a;
    a = 6.283185307 * real'($urandom_range(0, 65535)) / 65536.0;
    return cast_req(srand(-3200, 3200), srand(-3200, 3200),
                    $rtoi(16384.0 * $cos(a)), $rtoi(16384.0 * $sin(a)));
  endfunction

  function automatic ray_req_t local_load(int max_idx);
    int ax, ay;
    ax = srand(-350, 350);
    ay = srand(-350, 350);
    return load_req(srand(0, max_idx), ax, ay, ax + srand(-200, 200),
                    ay + srand(-200, 200), $urandom_range(0, 9) != 0);
  endfunction

  task automatic test_directed();
    write_reg(REG_SEG_COUNT, 4);
    set_bounds(-100, 100, -100, 100);
    send_request(load_req(0, 10, -50, 10, 50, 1));
    send_request(load_req(1, 10, -50, 10, 50, 1));       // tie with entry 0
    send_request(load_req(2, 20, 0, 20, 0, 1));          // degenerate wall
    send_request(load_req(3, 0, -5, 0, 5, 1));           // too close to the origin
    send_request(load_req(1023, -32768, -32768, 32767, 32767, 1));
    send_request(load_req(512, 32767, 32767, -32768, -32768, 0));
    send_request(cast_req(-4, 0, 16384, 0));
    send_request(cast_req(-4, 0, -16384, 0));            // left edge
    send_request(cast_req(0, 0, 0, 0));                  // no direction at all
    send_request(cast_req(16, 16, 16384, 16384));        // not unit length
    send_request(cast_req(-16, 0, -16384, -16384));
    send_request(cast_req(0, 960, 16384, 0));            // passes above the wall
    send_request(cast_req(0, 0, 0, 16384));
    send_request(cast_req(524287, -524288, -16384, 16384));
    set_bounds(100, -100, 100, -100);                    // inverted bounds
    send_request(cast_req(0, 0, 16384, 0));
    send_request(cast_req(0, 0, 0, -16384));
    set_bounds(-32768, 32767, -32768, 32767);
    send_request(cast_req(0, 0, -16384, 0));
    send_request(cast_req(-524288, 524287, 16384, -16384));
    write_reg(REG_SEG_COUNT, 0);
    send_request(cast_req(0, 0, 16384, 0));
  endtask

  task automatic test_random_phase(int pct, int items);
    int n;
    idle_pct = pct;
    n = srand(1, 12);
    write_reg(REG_SEG_COUNT, n);
    set_bounds(srand(-300, -50), srand(50, 300), srand(-300, -50), srand(50, 300));
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) wait_drained();                // let everything come back
      case ($urandom_range(0, 9))
        0:       send_request(load_req(srand(0, 1023), srand(-32768, 32767),
                                       srand(-32768, 32767), srand(-32768, 32767),
                                       srand(-32768, 32767), $urandom_range(0, 1)));
        1:       send_request(cast_req(srand(-524288, 524287), srand(-524288, 524287),
                                       srand(-16384, 16384), srand(-16384, 16384)));
        2, 3, 4: send_request(local_load(n + 2));
        default: send_request(local_cast());
      endcase
    end
  endtask

  task automatic test_full_table();
    idle_pct = 0;
    write_reg(REG_SEG_COUNT, 1024);
    set_bounds(-200, 200, -200, 200);
    send_request(local_load(1023));
    send_request(local_cast());
    send_request(local_cast());
    write_reg(REG_SEG_COUNT, 2047);                      // walk stops at the table end
    send_request(local_cast());
  endtask

  initial begin
    foreach (wall_blocks[i]) wall_blocks[i] = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_phase(29, 185);
    test_random_phase(46, 185);
    test_random_phase(0, 180);
    test_full_table();
    wait_drained();
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && !stray_result && pending_hits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> ray_wall_closest_hit_core.f
+incdir+sv
sv/rwch_pkg.sv
sv/rwch_div.sv
sv/rwch_sqrt.sv
sv/ray_wall_closest_hit_core.sv
sv/rwch_checker.sv
sim/tb_ray_wall_closest_hit_core.sv
